// ----- rtl/ptmo_pkg.sv -----
// ----------------------------------------------------------------------------
// ptmo_pkg
// Shared widths, codes and helpers for the peer time median offset block.
// ----------------------------------------------------------------------------
package ptmo_pkg;

    localparam int DefMaxSamples = 256;

    localparam int SampW  = 41;
    localparam int TimeW  = 40;
    localparam int AddrW  = 64;
    localparam int PortW  = 16;
    localparam int LimW   = 20;
    localparam int MinW   = 9;
    localparam int CfgIdxW = 8;
    localparam int PeerW  = 2 * AddrW + PortW;

    localparam logic [LimW-1:0] MaxOffsetRst  = LimW'(70 * 60);
    localparam logic [LimW-1:0] NearWindowRst = LimW'(5 * 60);
    localparam logic [MinW-1:0] MinSamplesRst = MinW'(5);

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_MAX_OFFSET  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] REG_NEAR_WINDOW = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] REG_MIN_SAMPLES = CfgIdxW'(2);

    // result status
    localparam logic [1:0] ST_TAKEN = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_KNOWN = 2'd2;

    typedef logic signed [SampW-1:0] t_samp;

    function automatic logic [SampW-1:0] magnitude(input t_samp v);
        logic [SampW-1:0] m;
        m = v[SampW-1] ? SampW'(-v) : SampW'(v);
        return m;
    endfunction

endpackage

// ----- rtl/ptmo_ram.sv -----
// ----------------------------------------------------------------------------
// ptmo_ram
// Single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
module ptmo_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/peer_time_median_offset.sv -----
// ----------------------------------------------------------------------------
// peer_time_median_offset
// Median filter of peer clock offsets with limit and one-time mismatch flag.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request walks the known-peer table
// (a read and a compare state per peer) and stops there if the peer is
// known; else it insertion-sorts its sample into the sample memory, reads
// the median when the count has reached the minimum and is odd, and, while
// no warning has been raised yet, scans the samples for agreement
// whenever the median is out of limit. The result is held until taken,
// then the next request is accepted. Memories need no clearing: only
// entries below the stored count are read.
module peer_time_median_offset
    import ptmo_pkg::*;
#(
    parameter int MAX_SAMPLES = DefMaxSamples
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [AddrW-1:0]          i_peer_addr_high,
    input  logic [AddrW-1:0]          i_peer_addr_low,
    input  logic [PortW-1:0]          i_peer_port,
    input  logic [TimeW-1:0]          i_remote_time,
    input  logic [TimeW-1:0]          i_local_time,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic                      o_offset_updated,
    output logic signed [SampW-1:0]   o_time_offset,
    output logic                      o_mismatch_warning,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_idx,
    input  logic [LimW-1:0]           i_cfg_data
);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int CMPW = (CW > MinW) ? CW : MinW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_INS_RD   = 4'd3;
    localparam logic [3:0] S_INS_CMP  = 4'd4;
    localparam logic [3:0] S_MED_CHK  = 4'd5;
    localparam logic [3:0] S_MED_CMP  = 4'd6;
    localparam logic [3:0] S_AGR_RD   = 4'd7;
    localparam logic [3:0] S_AGR_CMP  = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    t_samp            r_sample, n_sample;
    logic [PeerW-1:0] r_peer, n_peer;
    logic [1:0]       r_status, n_status;
    logic             r_upd, n_upd;
    logic             r_warn, n_warn;
    logic             r_reported, n_reported;
    t_samp            r_offset, n_offset;
    logic [LimW-1:0]  r_max, r_near;
    logic [MinW-1:0]  r_min;

    logic             samp_we, peer_we;
    logic [AW-1:0]    samp_wa, samp_ra, peer_wa, peer_ra;
    t_samp            samp_wd;
    logic [SampW-1:0] samp_rd;
    logic [PeerW-1:0] peer_rd;
    logic [CW-1:0]    idx_dec, mid_idx;
    logic [SampW-1:0] rd_mag;

    ptmo_ram #(.Width(SampW), .Depth(MAX_SAMPLES)) u_samp (
        .i_clk(i_clk), .i_we(samp_we), .i_waddr(samp_wa), .i_wdata(samp_wd),
        .i_raddr(samp_ra), .o_rdata(samp_rd)
    );

    ptmo_ram #(.Width(PeerW), .Depth(MAX_SAMPLES)) u_peer (
        .i_clk(i_clk), .i_we(peer_we), .i_waddr(peer_wa), .i_wdata(r_peer),
        .i_raddr(peer_ra), .o_rdata(peer_rd)
    );

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = (r_state == S_DONE);
    assign o_status           = r_status;
    assign o_offset_updated   = r_upd;
    assign o_time_offset      = r_offset;
    assign o_mismatch_warning = r_warn;

    assign idx_dec = r_idx - CW'(1);
    assign mid_idx = r_count >> 1;
    assign rd_mag  = magnitude(t_samp'(samp_rd));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_sample   = r_sample;
        n_peer     = r_peer;
        n_status   = r_status;
        n_upd      = r_upd;
        n_warn     = r_warn;
        n_reported = r_reported;
        n_offset   = r_offset;
        samp_we    = 1'b0;
        samp_wa    = r_idx[AW-1:0];
        samp_wd    = r_sample;
        samp_ra    = r_idx[AW-1:0];
        peer_we    = 1'b0;
        peer_wa    = r_count[AW-1:0];
        peer_ra    = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_peer   = {i_peer_addr_high, i_peer_addr_low, i_peer_port};
                    n_sample = t_samp'({1'b0, i_remote_time})
                             - t_samp'({1'b0, i_local_time});
                    n_status = ST_TAKEN;
                    n_upd    = 1'b0;
                    n_warn   = 1'b0;
                    n_idx    = '0;
                    if (r_count >= CW'(MAX_SAMPLES)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    // new peer: record it and start the insertion from the top
                    peer_we = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (peer_rd == r_peer) begin
                    n_status = ST_KNOWN;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_INS_RD: begin
                samp_ra = idx_dec[AW-1:0];
                if (r_idx == '0) begin
                    samp_we = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_MED_CHK;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                samp_we = 1'b1;
                if (t_samp'(samp_rd) > r_sample) begin
                    // move larger entry up one slot
                    samp_wd = t_samp'(samp_rd);
                    n_idx   = idx_dec;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_MED_CHK;
                end
            end
            S_MED_CHK: begin
                samp_ra = mid_idx[AW-1:0];
                if (CMPW'(r_count) >= CMPW'(r_min) && r_count[0]) begin
                    n_state = S_MED_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MED_CMP: begin
                n_upd = 1'b1;
                if (rd_mag >= SampW'(r_max)) begin
                    n_offset = '0;
                    n_idx    = '0;
                    n_state  = r_reported ? S_DONE : S_AGR_RD;
                end else begin
                    n_offset = t_samp'(samp_rd);
                    n_state  = S_DONE;
                end
            end
            S_AGR_RD: begin
                if (r_idx == r_count) begin
                    n_warn     = 1'b1;
                    n_reported = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_AGR_CMP;
                end
            end
            S_AGR_CMP: begin
                if (rd_mag != '0 && rd_mag < SampW'(r_near)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_AGR_RD;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_reported <= 1'b0;
            r_offset   <= '0;
            r_max      <= MaxOffsetRst;
            r_near     <= NearWindowRst;
            r_min      <= MinSamplesRst;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_reported <= n_reported;
            r_offset   <= n_offset;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_OFFSET:  r_max  <= i_cfg_data;
                    REG_NEAR_WINDOW: r_near <= i_cfg_data;
                    REG_MIN_SAMPLES: r_min  <= i_cfg_data[MinW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_sample <= n_sample;
        r_peer   <= n_peer;
        r_status <= n_status;
        r_upd    <= n_upd;
        r_warn   <= n_warn;
    end
endmodule

// ----- test/tb_peer_time_median_offset.sv -----
// ----------------------------------------------------------------------------
// tb_peer_time_median_offset
// Self-checking bench: random and directed peer time requests, predicted
// offsets compared field by field against every result of the block.
// ----------------------------------------------------------------------------
module tb_peer_time_median_offset;
    import ptmo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    typedef struct {
        logic [AddrW-1:0] addr_hi;
        logic [AddrW-1:0] addr_lo;
        logic [PortW-1:0] port;
        logic [TimeW-1:0] rmt_time;
        logic [TimeW-1:0] lcl_time;
    } peer_req_t;

    typedef struct {
        logic [1:0]       status;
        logic             updated;
        t_samp            offset;
        logic             warn;
    } offset_res_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [AddrW-1:0]   i_peer_addr_high = '0;
    logic [AddrW-1:0]   i_peer_addr_low = '0;
    logic [PortW-1:0]   i_peer_port = '0;
    logic [TimeW-1:0]   i_remote_time = '0;
    logic [TimeW-1:0]   i_local_time = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic               o_offset_updated;
    logic signed [SampW-1:0] o_time_offset;
    logic               o_mismatch_warning;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [LimW-1:0]    i_cfg_data = '0;

    peer_time_median_offset u_top (.*);

    always #5 i_clk = ~i_clk;

    // predicted block state
    logic [LimW-1:0]  max_off_q = MaxOffsetRst;
    logic [LimW-1:0]  near_win_q = NearWindowRst;
    logic [MinW-1:0]  min_samp_q = MinSamplesRst;
    t_samp            sorted_q [DefMaxSamples];
    peer_req_t        known_q [DefMaxSamples];
    int               n_samples = 0;
    logic             warned_q = 1'b0;
    t_samp            offset_q = '0;

    peer_req_t        pending_reqs [$];
    offset_res_t      expected_offsets [$];
    peer_req_t        peer_pool [$];
    int               errors = 0;

    function automatic logic [SampW-1:0] abs_samp(input t_samp v);
        t_samp m;
        m = (v < 0) ? -v : v;
        return m;
    endfunction

    task automatic predict_offset(input peer_req_t r);
        offset_res_t res;
        t_samp       s;
        t_samp       med;
        logic        agree;
        int          pos;
        res = '{ST_TAKEN, 1'b0, '0, 1'b0};
        if (n_samples >= DefMaxSamples) begin
            res.status = ST_FULL;
        end else begin
            for (int i = 0; i < n_samples; i++)
                if (known_q[i].addr_hi == r.addr_hi && known_q[i].addr_lo == r.addr_lo &&
                    known_q[i].port == r.port)
                    res.status = ST_KNOWN;
        end
        if (res.status == ST_TAKEN) begin
            known_q[n_samples] = r;
            s = t_samp'({1'b0, r.rmt_time}) - t_samp'({1'b0, r.lcl_time});
            pos = n_samples;
            while (pos > 0 && sorted_q[pos-1] > s) begin
                sorted_q[pos] = sorted_q[pos-1];
                pos--;
            end
            sorted_q[pos] = s;
            n_samples++;
            if (n_samples >= int'(min_samp_q) && n_samples % 2 == 1) begin
                med = sorted_q[n_samples/2];
                res.updated = 1'b1;
                if (abs_samp(med) >= SampW'(max_off_q)) begin
                    if (!warned_q) begin
                        agree = 1'b0;
                        for (int i = 0; i < n_samples; i++)
                            if (abs_samp(sorted_q[i]) != 0 &&
                                abs_samp(sorted_q[i]) < SampW'(near_win_q))
                                agree = 1'b1;
                        if (!agree) begin
                            warned_q = 1'b1;
                            res.warn = 1'b1;
                        end
                    end
                    med = '0;
                end
                offset_q = med;
            end
        end
        res.offset = offset_q;
        expected_offsets.push_back(res);
    endtask

    // request driver: bursts with random gaps
    peer_req_t cur_req;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        logic nv;
        nv = i_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_offset(cur_req);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    nv = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
        end
        i_valid <= nv;
        if (nv) begin
            i_peer_addr_high <= cur_req.addr_hi;
            i_peer_addr_low  <= cur_req.addr_lo;
            i_peer_port      <= cur_req.port;
            i_remote_time    <= cur_req.rmt_time;
            i_local_time     <= cur_req.lcl_time;
        end
    end

    // result monitor with its own stall pattern
    int          stall_mode = 0;
    int          mode_left = 0;
    int          stall_phase = 0;

    always @(posedge i_clk) begin
        offset_res_t e;
        logic        rdy;
        if (o_valid && i_ready && i_rst_n) begin
            if (expected_offsets.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0d", $time,
                         o_status, o_time_offset);
                errors++;
            end else begin
                e = expected_offsets.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_offset_updated !== e.updated) begin
                    $display("%0t: offset_updated expected %0d actual %0d", $time,
                             e.updated, o_offset_updated);
                    errors++;
                end
                if (o_time_offset !== e.offset) begin
                    $display("%0t: time_offset expected %0d actual %0d", $time,
                             e.offset, o_time_offset);
                    errors++;
                end
                if (o_mismatch_warning !== e.warn) begin
                    $display("%0t: mismatch_warning expected %0d actual %0d", $time,
                             e.warn, o_mismatch_warning);
                    errors++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1) != 0;
            2: rdy = (stall_phase % 7) < 3;
            default: rdy = ($urandom_range(0, 9) == 0);
        endcase
        i_ready <= i_rst_n ? rdy : 1'b0;
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_offsets.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MAX_OFFSET:  max_off_q = data;
            REG_NEAR_WINDOW: near_win_q = data;
            REG_MIN_SAMPLES: min_samp_q = data[MinW-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic peer_req_t mk_req(input logic [AddrW-1:0] ah, input logic [AddrW-1:0] al,
                                         input logic [PortW-1:0] p,
                                         input logic [TimeW-1:0] rt,
                                         input logic [TimeW-1:0] lt);
        peer_req_t r;
        r = '{ah, al, p, rt, lt};
        return r;
    endfunction

    function automatic peer_req_t rand_req();
        peer_req_t r;
        int        pick;
        int        kind;
        logic signed [TimeW:0] delta;
        pick = $urandom_range(0, 9);
        if (pick < 6 || peer_pool.size() == 0) begin
            r.addr_hi = {$urandom, $urandom};
            r.addr_lo = {$urandom, $urandom};
            r.port    = PortW'($urandom);
        end else begin
            r = peer_pool[$urandom_range(0, peer_pool.size() - 1)];
            if (pick == 8)
                r.addr_lo[$urandom_range(0, AddrW-1)] ^= 1'b1;
            else if (pick == 9)
                r.port = PortW'($urandom);
        end
        r.lcl_time = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            0: delta = '0;
            1, 2, 3, 4: delta = (TimeW+1)'($signed($urandom_range(0, 800)) - 400);
            5, 6, 7: delta = (TimeW+1)'($signed($urandom_range(0, 20000)) - 10000);
            default: delta = (TimeW+1)'($signed($urandom_range(0, 3000000)) - 1500000);
        endcase
        r.rmt_time = r.lcl_time + delta[TimeW-1:0];
        if (kind == 9)
            r.rmt_time = {$urandom, $urandom};
        peer_pool.push_back(r);
        return r;
    endfunction

    initial begin
        logic [LimW-1:0] v;
        int              nitems;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // agreeing sample keeps the warning quiet even with every median out of limit
        write_reg(REG_MAX_OFFSET, '0);
        write_reg(REG_NEAR_WINDOW, '1);
        write_reg(REG_MIN_SAMPLES, 20'd1);
        @(negedge i_clk);
        pending_reqs.push_back(mk_req('1, '1, '1, 40'd1005, 40'd1000));
        pending_reqs.push_back(mk_req('1, '1, '1, 40'd7, 40'd7));
        pending_reqs.push_back(mk_req('1, '1, '0, 40'd7, 40'd7));
        pending_reqs.push_back(mk_req('0, '0, '0, '0, '1));
        pending_reqs.push_back(mk_req('0, '0, '0, '1, '0));
        wait_idle();
        // no window: the next odd count out of limit raises the one-time warning
        write_reg(REG_NEAR_WINDOW, '0);
        write_reg(REG_MIN_SAMPLES, 20'd0);
        @(negedge i_clk);
        pending_reqs.push_back(mk_req('0, '0, '1, '1, '0));
        pending_reqs.push_back(mk_req(64'h1, '0, '0, 40'd50, 40'd60));
        pending_reqs.push_back(mk_req(64'h2, '0, '0, 40'd300, 40'd0));
        pending_reqs.push_back(mk_req(64'h3, '0, '0, 40'd300, 40'd300));
        wait_idle();
        // widest limits, masked count and ignored register index
        write_reg(REG_MAX_OFFSET, '1);
        write_reg(REG_NEAR_WINDOW, 20'd300);
        write_reg(REG_MIN_SAMPLES, '1);
        write_reg(CfgIdxW'(3), 20'd7);
        write_reg('1, 20'd7);
        @(negedge i_clk);
        pending_reqs.push_back(mk_req(64'h4, '1, 16'h8000, 40'h80_0000_0000, 40'h7F_FFFF_FFFF));
        pending_reqs.push_back(mk_req(64'h4, '1, 16'h8000, 40'd0, 40'd0));
        pending_reqs.push_back(mk_req(64'h5, '1, 16'h1, 40'd1, 40'd0));
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 4))
                0: v = '0;
                1: v = '1;
                2: v = MaxOffsetRst;
                3: v = LimW'($urandom_range(0, 2000));
                default: v = LimW'($urandom);
            endcase
            write_reg(REG_MAX_OFFSET, v);
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = '1;
                2: v = NearWindowRst;
                default: v = LimW'($urandom);
            endcase
            write_reg(REG_NEAR_WINDOW, v);
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = 20'd1;
                2: v = 20'd256;
                3: v = LimW'($urandom);
                default: v = LimW'($urandom_range(1, 40));
            endcase
            write_reg(REG_MIN_SAMPLES, v);
            @(negedge i_clk);
            nitems = $urandom_range(60, 100);
            for (int k = 0; k < nitems; k++)
                pending_reqs.push_back(rand_req());
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_offsets.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
